// File: src/j1939_bam_pkg.sv
// Shared types, constants and helpers for the J1939 BAM segmenter.
// No dependencies; imported by every module of the block.
`default_nettype none

package j1939_bam_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SINGLE,
        MODE_BAM
    } mode_t;

    // One emitted CAN frame; data byte k sits at data[8k+7:8k].
    typedef struct packed {
        logic [28:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic        done;
    } frame_t;

    localparam logic [10:0] BAM_MAX_LEN  = 11'd1785;
    localparam logic [10:0] SINGLE_MAX   = 11'd8;
    localparam logic [7:0]  PF_BAM_CM    = 8'd236;
    localparam logic [7:0]  PF_BAM_DT    = 8'd235;
    localparam logic [7:0]  PF_PDU2_MIN  = 8'd240;
    localparam logic [7:0]  GLOBAL_ADDR  = 8'hFF;
    localparam logic [7:0]  CM_CTRL_BAM  = 8'd32;
    localparam logic [7:0]  PAD_BYTE     = 8'hFF;
    localparam logic [2:0]  TP_PRIORITY  = 3'd7;
    localparam logic [3:0]  FULL_DLC     = 4'd8;
    localparam logic [2:0]  DT_LAST_FILL = 3'd7;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    // floor(x / 7) == (x * 2341) >> 14 for every x below 5461
    localparam logic [11:0] RECIP7       = 12'd2341;
    localparam int          RECIP7_SHIFT = 14;

    function automatic logic [28:0] tp_id(input logic [7:0] pf, input logic [7:0] sa);
        tp_id = {TP_PRIORITY, 2'b00, pf, GLOBAL_ADDR, sa};
    endfunction

    function automatic logic [63:0] set_byte(input logic [63:0] buf_in,
                                             input logic [2:0]  pos,
                                             input logic [7:0]  val);
        logic [63:0] r;
        r = buf_in;
        for (int k = 0; k < 8; k++) begin
            if (pos == 3'(k)) begin
                r[8*k +: 8] = val;
            end
        end
        set_byte = r;
    endfunction

endpackage

`default_nettype wire

// File: src/j1939_bam_seg.sv
// Segmenter state and frame builder: one registered word in, at most one frame out.
// Depends on j1939_bam_pkg.
`default_nettype none

module j1939_bam_seg
    import j1939_bam_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        first_byte,
    input  wire logic [28:0] message_id,
    input  wire logic [10:0] total_length,
    input  wire logic [7:0]  payload_byte,
    output logic             res_valid,
    output frame_t           res_frame
);

    mode_t       mode_reg, mode_next;
    logic [10:0] left_reg, left_next;
    logic [7:0]  seq_reg, seq_next;
    logic [2:0]  fill_reg, fill_next;
    logic [63:0] buf_reg, buf_next;
    logic [28:0] hid_reg, hid_next;
    logic [3:0]  hlen_reg, hlen_next;

    logic [7:0]  sa, ps, pf, pgn_ps;
    logic [11:0] len_round;
    logic [23:0] pkt_prod;
    logic [7:0]  packets;
    logic [63:0] cm_data;

    assign sa        = message_id[7:0];
    assign ps        = message_id[15:8];
    assign pf        = message_id[23:16];
    assign pgn_ps    = (pf < PF_PDU2_MIN) ? 8'h00 : ps;
    assign len_round = {1'b0, total_length} + 12'd6;
    assign pkt_prod  = {12'b0, len_round} * {12'b0, RECIP7};
    assign packets   = pkt_prod[RECIP7_SHIFT +: 8];
    assign cm_data   = {6'b0, message_id[25:24], pf, pgn_ps, PAD_BYTE,
                        packets, 5'b0, total_length[10:8], total_length[7:0], CM_CTRL_BAM};

    always_comb
    begin
        logic [63:0] buf1;
        logic [10:0] left1;
        logic [2:0]  fill1;
        logic [2:0]  pos;
        logic        done;

        mode_next = mode_reg;
        left_next = left_reg;
        seq_next  = seq_reg;
        fill_next = fill_reg;
        buf_next  = buf_reg;
        hid_next  = hid_reg;
        hlen_next = hlen_reg;
        res_valid = 1'b0;
        res_frame = '0;
        buf1      = buf_reg;
        left1     = left_reg;
        fill1     = fill_reg;
        pos       = 3'd0;
        done      = 1'b0;

        if (step) begin
            if (first_byte) begin
                // any start word abandons what was in progress
                mode_next = MODE_IDLE;
                buf_next  = ALL_ONES;
                fill_next = 3'd0;
                seq_next  = 8'd0;
                left_next = 11'd0;
                priority if (total_length == 11'd0) begin
                    hid_next  = message_id;
                    hlen_next = 4'd0;
                    res_valid = 1'b1;
                    res_frame = '{id: message_id, len: 4'd0, data: ALL_ONES, done: 1'b1};
                end
                else if (total_length <= SINGLE_MAX) begin
                    hid_next  = message_id;
                    hlen_next = total_length[3:0];
                    buf1      = set_byte(ALL_ONES, 3'd0, payload_byte);
                    left1     = total_length - 11'd1;
                    if (left1 == 11'd0) begin
                        res_valid = 1'b1;
                        res_frame = '{id: message_id, len: total_length[3:0],
                                      data: buf1, done: 1'b1};
                    end
                    else begin
                        mode_next = MODE_SINGLE;
                        buf_next  = buf1;
                        left_next = left1;
                    end
                end
                else if (total_length > BAM_MAX_LEN) begin
                    // too long: dropped
                end
                else if (pf < PF_PDU2_MIN && ps != GLOBAL_ADDR) begin
                    // destination-specific long message: dropped
                end
                else begin
                    hid_next  = tp_id(PF_BAM_DT, sa);
                    hlen_next = FULL_DLC;
                    seq_next  = 8'd1;
                    buf_next  = set_byte(set_byte(ALL_ONES, 3'd0, 8'd1), 3'd1, payload_byte);
                    fill_next = 3'd1;
                    left_next = total_length - 11'd1;
                    mode_next = MODE_BAM;
                    res_valid = 1'b1;
                    res_frame = '{id: tp_id(PF_BAM_CM, sa), len: FULL_DLC,
                                  data: cm_data, done: 1'b0};
                end
            end
            else begin
                unique case (mode_reg)
                    MODE_SINGLE:
                    begin
                        pos   = hlen_reg[2:0] - left_reg[2:0];
                        buf1  = set_byte(buf_reg, pos, payload_byte);
                        left1 = left_reg - 11'd1;
                        left_next = left1;
                        if (left1 == 11'd0) begin
                            res_valid = 1'b1;
                            res_frame = '{id: hid_reg, len: hlen_reg, data: buf1, done: 1'b1};
                            mode_next = MODE_IDLE;
                            buf_next  = ALL_ONES;
                        end
                        else begin
                            buf_next = buf1;
                        end
                    end
                    MODE_BAM:
                    begin
                        buf1  = set_byte(set_byte(buf_reg, 3'd0, seq_reg),
                                         fill_reg + 3'd1, payload_byte);
                        fill1 = fill_reg + 3'd1;
                        left1 = left_reg - 11'd1;
                        done  = (left1 == 11'd0);
                        left_next = left1;
                        if (fill1 == DT_LAST_FILL || done) begin
                            res_valid = 1'b1;
                            res_frame = '{id: hid_reg, len: FULL_DLC, data: buf1, done: done};
                            buf_next  = ALL_ONES;
                            fill_next = 3'd0;
                            seq_next  = seq_reg + 8'd1;
                            if (done) begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        else begin
                            buf_next  = buf1;
                            fill_next = fill1;
                        end
                    end
                    default:
                    begin
                        // idle: stray byte ignored
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            left_reg <= 11'd0;
            seq_reg  <= 8'd0;
            fill_reg <= 3'd0;
            buf_reg  <= ALL_ONES;
            hid_reg  <= 29'd0;
            hlen_reg <= 4'd0;
        end
        else begin
            mode_reg <= mode_next;
            left_reg <= left_next;
            seq_reg  <= seq_next;
            fill_reg <= fill_next;
            buf_reg  <= buf_next;
            hid_reg  <= hid_next;
            hlen_reg <= hlen_next;
        end
    end

endmodule

`default_nettype wire

// File: src/j1939_bam_outq.sv
// Output register with one skid entry for emitted frames.
// Depends on j1939_bam_pkg.
`default_nettype none

module j1939_bam_outq
    import j1939_bam_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire frame_t push_frame,
    input  wire logic   out_stall,
    output logic        out_valid,
    output frame_t      out_frame,
    output logic        skid_full
);

    logic   ov_reg, ov_next;
    logic   sv_reg, sv_next;
    frame_t of_reg, of_next;
    frame_t sf_reg, sf_next;
    logic   pop;

    assign pop       = ov_reg & ~out_stall;
    assign out_valid = ov_reg;
    assign out_frame = of_reg;
    assign skid_full = sv_reg;

    always_comb
    begin
        ov_next = ov_reg;
        sv_next = sv_reg;
        of_next = of_reg;
        sf_next = sf_reg;
        if (pop) begin
            ov_next = 1'b0;
        end
        // push only arrives while the skid entry is empty
        if (sv_reg) begin
            if (pop) begin
                ov_next = 1'b1;
                of_next = sf_reg;
                sv_next = 1'b0;
            end
        end
        else if (push) begin
            if (!ov_reg || pop) begin
                ov_next = 1'b1;
                of_next = push_frame;
            end
            else begin
                sv_next = 1'b1;
                sf_next = push_frame;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else begin
            ov_reg <= ov_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        of_reg <= of_next;
        sf_reg <= sf_next;
    end

endmodule

`default_nettype wire

// File: src/j1939_bam_segmenter_core.sv
// Top level of the J1939 BAM segmenter: input register, segmenter, output queue.
// Depends on j1939_bam_pkg, j1939_bam_seg and j1939_bam_outq.
//
//   channel | handshake           | word
//   --------+---------------------+-------------------------------------------------
//   in      | in_valid / in_stall | first_byte, message_id, total_length, payload_byte
//   out     | out_valid/out_stall | frame_id, frame_length, data_0..7, message_done
//
// Throughput is one input word per clock while in_stall is low; each word yields zero or one frame.
// A word is captured in the input register; the segmenter state update and frame
// build then land in the output register, or in the skid entry while that register is held.
// in_stall rises only when the input register holds a word and the output
// skid entry is also full, i.e. after the output side has stalled for a while.
// rst_n is asynchronous; it empties the pipeline and returns the segmenter to idle.
`default_nettype none

module j1939_bam_segmenter_core
    import j1939_bam_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        first_byte,
    input  wire logic [28:0] message_id,
    input  wire logic [10:0] total_length,
    input  wire logic [7:0]  payload_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [28:0]      frame_id,
    output logic [3:0]       frame_length,
    output logic [7:0]       data_0,
    output logic [7:0]       data_1,
    output logic [7:0]       data_2,
    output logic [7:0]       data_3,
    output logic [7:0]       data_4,
    output logic [7:0]       data_5,
    output logic [7:0]       data_6,
    output logic [7:0]       data_7,
    output logic             message_done
);

    // input register
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_first_reg;
    logic [28:0] s1_id_reg;
    logic [10:0] s1_len_reg;
    logic [7:0]  s1_byte_reg;

    logic   accept;
    logic   advance;
    logic   skid_full;
    logic   res_valid;
    frame_t res_frame;
    frame_t out_frame;

    // the registered word moves on whenever the queue has a free slot
    assign advance       = s1_valid_reg & ~skid_full;
    assign in_stall      = s1_valid_reg & skid_full;
    assign accept        = in_valid & ~in_stall;
    assign s1_valid_next = accept | (s1_valid_reg & ~advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_first_reg <= first_byte;
            s1_id_reg    <= message_id;
            s1_len_reg   <= total_length;
            s1_byte_reg  <= payload_byte;
        end
    end

    j1939_bam_seg u_seg (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .first_byte   (s1_first_reg),
        .message_id   (s1_id_reg),
        .total_length (s1_len_reg),
        .payload_byte (s1_byte_reg),
        .res_valid    (res_valid),
        .res_frame    (res_frame)
    );

    j1939_bam_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_frame (res_frame),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_frame  (out_frame),
        .skid_full  (skid_full)
    );

    assign frame_id     = out_frame.id;
    assign frame_length = out_frame.len;
    assign data_0       = out_frame.data[7:0];
    assign data_1       = out_frame.data[15:8];
    assign data_2       = out_frame.data[23:16];
    assign data_3       = out_frame.data[31:24];
    assign data_4       = out_frame.data[39:32];
    assign data_5       = out_frame.data[47:40];
    assign data_6       = out_frame.data[55:48];
    assign data_7       = out_frame.data[63:56];
    assign message_done = out_frame.done;

endmodule

`default_nettype wire

// File: verif/j1939_bam_segmenter_core_tb.sv
// Self-checking testbench for j1939_bam_segmenter_core: directed table, then random messages.
// Depends on j1939_bam_pkg and the RTL of the segmenter; nothing else is read.
`timescale 1ns / 100ps

module j1939_bam_segmenter_core_tb;
    import j1939_bam_pkg::*;

    localparam int RUN_LIMIT    = 500000; // cycles; far above the slowest correct run
    localparam int DRAIN_CYCLES = 20;     // idle clocks run after all expected frames have been seen
    localparam int PHASE_WORDS  = 225;    // least number of random message words per idling phase

    // How a directed row is checked: by the predictor, against a typed-in answer, or as giving no frame.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_FRAME
    } row_check_t;

    typedef struct {
        logic        first;
        logic [28:0] id;
        logic [10:0] len;
        logic [7:0]  pb;
        row_check_t  chk;
        frame_t      want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        first_byte;
    logic [28:0] message_id;
    logic [10:0] total_length;
    logic [7:0]  payload_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [7:0]  data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7;
    logic        message_done;

    // Predictor state: a private copy of the segmenter's registers.
    mode_t       seg_mode;
    logic [10:0] seg_left;
    logic [7:0]  seg_seq;
    logic [2:0]  seg_fill;
    logic [63:0] seg_buf;
    logic [28:0] seg_id;
    logic [3:0]  seg_dlc;

    frame_t      pending_frames[$];   // frames the block still owes, oldest first
    stim_row_t   directed_rows[$];
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int          words_sent;

    j1939_bam_segmenter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_byte   (first_byte),
        .message_id   (message_id),
        .total_length (total_length),
        .payload_byte (payload_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .data_0       (data_0),
        .data_1       (data_1),
        .data_2       (data_2),
        .data_3       (data_3),
        .data_4       (data_4),
        .data_5       (data_5),
        .data_6       (data_6),
        .data_7       (data_7),
        .message_done (message_done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a lost frame ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Advance the segmenter by one accepted word; returns 1 when a frame comes out.
    function automatic bit segment_word(input logic        first,
                                        input logic [28:0] id,
                                        input logic [10:0] len,
                                        input logic [7:0]  pb,
                                        output frame_t     fr);
        logic [7:0]  sa;
        logic [7:0]  ps;
        logic [7:0]  pf;
        logic [7:0]  pgn_ps;
        logic [10:0] packets;
        logic [2:0]  pos;
        fr = '0;
        if (first)
        begin
            sa = id[7:0];
            ps = id[15:8];
            pf = id[23:16];
            // PDU1 PGNs carry a zero PS byte
            pgn_ps = (pf < PF_PDU2_MIN) ? 8'h00 : ps;
            // a new header always abandons whatever was in progress
            seg_mode = MODE_IDLE;
            seg_buf  = ALL_ONES;
            seg_fill = '0;
            seg_seq  = '0;
            seg_left = '0;
            if (len == 11'd0)
            begin
                seg_id   = id;
                seg_dlc  = 4'd0;
                fr.id    = id;
                fr.len   = 4'd0;
                fr.data  = ALL_ONES;
                fr.done  = 1'b1;
                return 1'b1;
            end
            if (len <= SINGLE_MAX)
            begin
                seg_id   = id;
                seg_dlc  = len[3:0];
                seg_left = len;
                seg_mode = MODE_SINGLE;
                // falls through: this word's byte is the first payload byte
            end
            else
            begin
                if (len > BAM_MAX_LEN)
                    return 1'b0;
                // destination-specific long messages need RTS/CTS: dropped
                if (pf < PF_PDU2_MIN && ps != GLOBAL_ADDR)
                    return 1'b0;
                packets  = (len + 11'd6) / 11'd7;
                fr.id    = {TP_PRIORITY, 2'b00, PF_BAM_CM, GLOBAL_ADDR, sa};
                fr.len   = FULL_DLC;
                fr.data  = {6'd0, id[25:24], pf, pgn_ps, PAD_BYTE, packets[7:0],
                            5'd0, len[10:8], len[7:0], CM_CTRL_BAM};
                fr.done  = 1'b0;
                seg_id   = {TP_PRIORITY, 2'b00, PF_BAM_DT, GLOBAL_ADDR, sa};
                seg_dlc  = FULL_DLC;
                seg_seq  = 8'd1;
                seg_buf  = {ALL_ONES[63:16], pb, 8'd1};
                seg_fill = 3'd1;
                seg_left = len - 11'd1;
                seg_mode = MODE_BAM;
                return 1'b1;
            end
        end

        if (seg_mode == MODE_SINGLE)
        begin
            pos = 3'({7'd0, seg_dlc} - seg_left);
            seg_buf[8*pos +: 8] = pb;
            seg_left = seg_left - 11'd1;
            if (seg_left == 11'd0)
            begin
                fr.id    = seg_id;
                fr.len   = seg_dlc;
                fr.data  = seg_buf;
                fr.done  = 1'b1;
                seg_mode = MODE_IDLE;
                seg_buf  = ALL_ONES;
                return 1'b1;
            end
            return 1'b0;
        end

        if (seg_mode == MODE_BAM)
        begin
            // byte 0 of a TP.DT frame is its sequence number
            seg_buf[7:0] = seg_seq;
            seg_buf[8*(seg_fill + 1) +: 8] = pb;
            seg_fill = seg_fill + 3'd1;
            seg_left = seg_left - 11'd1;
            if (seg_fill == DT_LAST_FILL || seg_left == 11'd0)
            begin
                fr.id    = seg_id;
                fr.len   = FULL_DLC;
                fr.data  = seg_buf;
                fr.done  = (seg_left == 11'd0);
                seg_buf  = ALL_ONES;
                seg_fill = '0;
                seg_seq  = seg_seq + 8'd1;
                if (seg_left == 11'd0)
                    seg_mode = MODE_IDLE;
                return 1'b1;
            end
            return 1'b0;
        end

        // a byte outside any message is ignored
        return 1'b0;
    endfunction

    // Offer one word with random gaps ahead of it, hold it through stalls, then predict.
    task automatic send_word(input logic        first,
                             input logic [28:0] id,
                             input logic [10:0] len,
                             input logic [7:0]  pb,
                             input row_check_t  chk,
                             input frame_t      typed);
        frame_t predicted;
        bit     has_frame;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_byte   <= first;
        message_id   <= id;
        total_length <= len;
        payload_byte <= pb;
        do
            @(posedge clk);
        while (in_stall);
        has_frame = segment_word(first, id, len, pb, predicted);
        if (chk == CHK_FRAME)
            pending_frames.push_back(typed);
        else if (chk == CHK_MODEL && has_frame)
            pending_frames.push_back(predicted);
    endtask

    // One random message: mostly well-formed, some dropped, cut short, or stray bytes.
    task automatic send_random_message();
        int          pick;
        int          n_words;
        bit          dropped;
        logic [28:0] id;
        logic [10:0] len;
        pick = $urandom_range(99);
        id   = 29'($urandom);
        if (pick < 6)
        begin
            // stray words: ignored when idle, otherwise they extend a cut-off message
            repeat ($urandom_range(1, 3))
                send_word(1'b0, 29'($urandom), 11'($urandom), 8'($urandom), CHK_MODEL, '0);
            return;
        end
        if (pick < 45)
            len = 11'($urandom_range(0, 8));
        else if (pick < 82)
            len = 11'($urandom_range(9, 60));
        else if (pick < 85)
            len = 11'($urandom_range(61, 400));
        else if (pick < 90)
            len = 11'($urandom_range(1786, 2047));
        else
            len = 11'($urandom_range(9, 40));
        // keep most long PDU1 messages broadcast so they get past the header
        if (len > SINGLE_MAX && id[23:16] < PF_PDU2_MIN && $urandom_range(9) != 0)
            id[15:8] = GLOBAL_ADDR;
        dropped = (len > BAM_MAX_LEN) ||
                  (len > SINGLE_MAX && id[23:16] < PF_PDU2_MIN && id[15:8] != GLOBAL_ADDR);
        n_words = (dropped || len == 11'd0) ? 1 : int'(len);
        if (pick >= 90)
            n_words = $urandom_range(1, int'(len) - 1);
        for (int i = 0; i < n_words; i++)
        begin
            // header fields carry junk on every word but the first
            if (i == 0)
                send_word(1'b1, id, len, 8'($urandom), CHK_MODEL, '0);
            else
                send_word(1'b0, 29'($urandom), 11'($urandom), 8'($urandom), CHK_MODEL, '0);
        end
        words_sent += n_words;
    endtask

    function automatic stim_row_t stim_row(input logic        first,
                                           input logic [28:0] id,
                                           input logic [10:0] len,
                                           input logic [7:0]  pb,
                                           input row_check_t  chk,
                                           input frame_t      want);
        stim_row_t r;
        r.first = first;
        r.id    = id;
        r.len   = len;
        r.pb    = pb;
        r.chk   = chk;
        r.want  = want;
        return r;
    endfunction

    task automatic note_failure(input string what, input frame_t want, input frame_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s at cycle %0d", what, cycle_count);
            $display("  expected id=%h len=%0d data=%h done=%b",
                     want.id, want.len, want.data, want.done);
            $display("  actual   id=%h len=%0d data=%h done=%b",
                     got.id, got.len, got.data, got.done);
        end
    endtask

    // Receiver: random stall, and every accepted frame checked against the oldest expectation.
    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            got.id   = frame_id;
            got.len  = frame_length;
            got.data = {data_7, data_6, data_5, data_4, data_3, data_2, data_1, data_0};
            got.done = message_done;
            if (pending_frames.size() == 0)
                note_failure("unexpected frame", '0, got);
            else
            begin
                want = pending_frames.pop_front();
                if (got.id !== want.id || got.len !== want.len ||
                    got.data !== want.data || got.done !== want.done)
                    note_failure("frame mismatch", want, got);
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        first_byte   <= 1'b0;
        message_id   <= '0;
        total_length <= '0;
        payload_byte <= '0;
        seg_mode = MODE_IDLE;
        seg_left = '0;
        seg_seq  = '0;
        seg_fill = '0;
        seg_buf  = ALL_ONES;
        seg_id   = '0;
        seg_dlc  = '0;

        // Directed table. Typed answers: CM frame ids are {7, 0, EC, FF, SA};
        // data literals read byte 7 on the left, byte 0 on the right.
        // byte outside a message, straight after reset
        directed_rows.push_back(stim_row(1'b0, 29'h0, 11'd0, 8'h5A, CHK_NONE, '0));
        // zero length: DLC 0, all pad, done
        directed_rows.push_back(stim_row(1'b1, 29'h1FFF_FFFF, 11'd0, 8'hAB, CHK_FRAME,
                                         {29'h1FFF_FFFF, 4'd0, ALL_ONES, 1'b1}));
        // one-byte single frame
        directed_rows.push_back(stim_row(1'b1, 29'h0, 11'd1, 8'h00, CHK_FRAME,
                                         {29'h0, 4'd1, 64'hFFFF_FFFF_FFFF_FF00, 1'b1}));
        // three-byte single frame, junk header on follow-on words
        directed_rows.push_back(stim_row(1'b1, 29'h0CF0_0417, 11'd3, 8'hFF, CHK_MODEL, '0));
        directed_rows.push_back(stim_row(1'b0, 29'h1FFF_FFFF, 11'h7FF, 8'h00, CHK_MODEL, '0));
        directed_rows.push_back(stim_row(1'b0, 29'h0, 11'd0, 8'h80, CHK_MODEL, '0));
        // too long: dropped, and the next byte finds the block idle
        directed_rows.push_back(stim_row(1'b1, 29'h1CFE_CA55, 11'd2047, 8'h11, CHK_NONE, '0));
        directed_rows.push_back(stim_row(1'b0, 29'h0, 11'd5, 8'h22, CHK_NONE, '0));
        directed_rows.push_back(stim_row(1'b1, 29'h18FE_CA55, 11'd1786, 8'h33, CHK_NONE, '0));
        // destination-specific long message (PF EF, PS 12): dropped
        directed_rows.push_back(stim_row(1'b1, 29'h18EF_1234, 11'd9, 8'h44, CHK_NONE, '0));
        // nine-byte PDU2 broadcast: CM, then DT 1 (seven bytes) and DT 2 (two bytes)
        directed_rows.push_back(stim_row(1'b1, 29'h1BFE_CA55, 11'd9, 8'hA0, CHK_FRAME,
                                         {29'h1CEC_FF55, 4'd8, 64'h03FE_CAFF_0200_0920, 1'b0}));
        for (int b = 1; b <= 8; b++)
            directed_rows.push_back(stim_row(1'b0, 29'h0, 11'd0, 8'(8'hA0 + b), CHK_MODEL, '0));
        // longest BAM, PDU1 to global: 255 packets, PS byte of the PGN zero
        directed_rows.push_back(stim_row(1'b1, 29'h00EA_FF00, 11'd1785, 8'h01, CHK_FRAME,
                                         {29'h1CEC_FF00, 4'd8, 64'h00EA_00FF_FF06_F920, 1'b0}));
        directed_rows.push_back(stim_row(1'b0, 29'h0, 11'd0, 8'h02, CHK_MODEL, '0));
        directed_rows.push_back(stim_row(1'b0, 29'h0, 11'd0, 8'h03, CHK_MODEL, '0));
        // new header mid-message abandons the long one
        directed_rows.push_back(stim_row(1'b1, 29'h1555_5555, 11'd2, 8'h0F, CHK_MODEL, '0));
        directed_rows.push_back(stim_row(1'b0, 29'h0, 11'd0, 8'hF0, CHK_MODEL, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].first, directed_rows[i].id, directed_rows[i].len,
                      directed_rows[i].pb, directed_rows[i].chk, directed_rows[i].want);

        // Random part, one idling profile per phase.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                end
                default:
                begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase
            words_sent = 0;
            while (words_sent < PHASE_WORDS)
                send_random_message();
        end

        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/j1939_bam_pkg.sv
src/j1939_bam_seg.sv
src/j1939_bam_outq.sv
src/j1939_bam_segmenter_core.sv
verif/j1939_bam_segmenter_core_tb.sv
